// File: design/cdq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_pkg: shared types for the circular double-ended queue
// Operation and status codes and the packed input and result words.
// ----------------------------------------------------------------------------
package cdq_pkg;

  localparam int unsigned WORD_W  = 64;
  localparam int unsigned COUNT_W = 11;

  typedef enum logic [1:0] {
    KIND_PUSH_BACK = 2'd0,
    KIND_POP_FRONT = 2'd1,
    KIND_POP_BACK  = 2'd2,
    KIND_CLEAR     = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_POP_EMPTY  = 2'd1,
    STATUS_PUSH_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    kind_t              kind;
    logic [WORD_W-1:0]  value;
  } in_word_t;

  typedef struct packed {
    logic [WORD_W-1:0]  popped_value;
    status_t            status;
    logic [COUNT_W-1:0] count;
    logic               is_empty;
    logic               is_full;
    logic [WORD_W-1:0]  front_value;
    logic [WORD_W-1:0]  back_value;
  } out_word_t;

endpackage

// File: design/cdq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_ram: generic RAM with one write port and two registered read ports
// A read at the address being written returns the old contents.
// ----------------------------------------------------------------------------
module cdq_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  output logic [WIDTH-1:0]         rd_data_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

// File: design/circular_double_ended_queue_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_double_ended_queue_core: fixed-capacity deque of 64-bit words
// Push back, pop front, pop back and clear on a circular RAM store.
//
//   Channel | Ports                          | Word type
//   --------+--------------------------------+-------------------
//   input   | in_valid, in_stall, in_word    | cdq_pkg::in_word_t
//   result  | out_valid, out_stall, out_word | cdq_pkg::out_word_t
//
// One word is accepted per cycle while in_stall is low, and its result is
// registered in the output stage. The front and back words live in
// registers, and the RAM's two read ports keep the next-inner words fetched
// for every cycle. A two-entry output stage holds results while out_stall is
// high; in_stall rises only when both entries are full. Reset empties the
// queue at once; the RAM contents are not cleared.
// ----------------------------------------------------------------------------
module circular_double_ended_queue_core #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  cdq_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output cdq_pkg::out_word_t out_word
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned WW = cdq_pkg::WORD_W;
  localparam int unsigned OW = cdq_pkg::COUNT_W;
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  function automatic logic [AW-1:0] next_idx(input logic [AW-1:0] i);
    return (i == LAST_IDX) ? '0 : i + AW'(1);
  endfunction

  function automatic logic [AW-1:0] prev_idx(input logic [AW-1:0] i);
    return (i == '0) ? LAST_IDX : i - AW'(1);
  endfunction

  logic [AW-1:0] front_r, front_nxt;
  logic [AW-1:0] back_r, back_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [WW-1:0] front_word_r, front_word_nxt;
  logic [WW-1:0] back_word_r, back_word_nxt;

  logic          wr_en;
  logic [AW-1:0] rd_addr_a, rd_addr_b;
  logic [WW-1:0] ram_a, ram_b, rd_a, rd_b;
  logic          byp_a_r, byp_b_r;
  logic [WW-1:0] byp_data_r;

  logic               accept;
  logic               is_empty, is_full;
  cdq_pkg::out_word_t res;
  cdq_pkg::out_word_t skid_r;
  logic               out_valid_r, skid_valid_r;
  cdq_pkg::out_word_t out_word_r;
  logic [CW+OW-1:0]   cnt_ext;

  assign accept   = in_valid && !in_stall;
  assign in_stall = skid_valid_r;
  assign is_empty = (cnt_r == '0);
  assign is_full  = (cnt_r == FULL_CNT);

  always_comb begin
    front_nxt      = front_r;
    back_nxt       = back_r;
    cnt_nxt        = cnt_r;
    front_word_nxt = front_word_r;
    back_word_nxt  = back_word_r;
    wr_en          = 1'b0;
    res            = '0;
    res.status     = cdq_pkg::STATUS_OK;
    if (accept) begin
      unique case (in_word.kind)
        cdq_pkg::KIND_PUSH_BACK: begin
          if (is_full) begin
            res.status = cdq_pkg::STATUS_PUSH_FULL;
          end else begin
            wr_en         = 1'b1;
            back_nxt      = next_idx(back_r);
            cnt_nxt       = cnt_r + CW'(1);
            back_word_nxt = in_word.value;
            if (is_empty) begin
              front_word_nxt = in_word.value;
            end
          end
        end
        cdq_pkg::KIND_POP_FRONT: begin
          if (is_empty) begin
            res.status = cdq_pkg::STATUS_POP_EMPTY;
          end else begin
            res.popped_value = front_word_r;
            front_nxt        = next_idx(front_r);
            cnt_nxt          = cnt_r - CW'(1);
            front_word_nxt   = rd_a;
          end
        end
        cdq_pkg::KIND_POP_BACK: begin
          if (is_empty) begin
            res.status = cdq_pkg::STATUS_POP_EMPTY;
          end else begin
            res.popped_value = back_word_r;
            back_nxt         = prev_idx(back_r);
            cnt_nxt          = cnt_r - CW'(1);
            back_word_nxt    = rd_b;
          end
        end
        cdq_pkg::KIND_CLEAR: begin
          front_nxt = '0;
          back_nxt  = '0;
          cnt_nxt   = '0;
        end
      endcase
    end
    cnt_ext      = {{OW{1'b0}}, cnt_nxt};
    res.count    = cnt_ext[OW-1:0];
    res.is_empty = (cnt_nxt == '0);
    res.is_full  = (cnt_nxt == FULL_CNT);
    if (cnt_nxt != '0) begin
      res.front_value = front_word_nxt;
      res.back_value  = back_word_nxt;
    end
  end

  // The read ports always fetch the second word from each end of the next state.
  assign rd_addr_a = next_idx(front_nxt);
  assign rd_addr_b = prev_idx(prev_idx(back_nxt));

  cdq_ram #(
    .WIDTH (WW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (back_r),
    .wr_data   (in_word.value),
    .rd_addr_a (rd_addr_a),
    .rd_data_a (ram_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_b (ram_b)
  );

  always_ff @(posedge clk) begin
    byp_a_r    <= wr_en && (back_r == rd_addr_a);
    byp_b_r    <= wr_en && (back_r == rd_addr_b);
    byp_data_r <= in_word.value;
  end

  assign rd_a = byp_a_r ? byp_data_r : ram_a;
  assign rd_b = byp_b_r ? byp_data_r : ram_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      back_r  <= '0;
      cnt_r   <= '0;
    end else begin
      front_r <= front_nxt;
      back_r  <= back_nxt;
      cnt_r   <= cnt_nxt;
    end
    front_word_r <= front_word_nxt;
    back_word_r  <= back_word_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= accept;
      end
    end else if (accept) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || !out_stall) begin
      out_word_r <= skid_valid_r ? skid_r : res;
    end else if (accept) begin
      skid_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  logic [AW:0] span;
  assign span = (back_r >= front_r) ? ({1'b0, back_r} - {1'b0, front_r})
                                    : ({1'b0, back_r} + (AW+1)'(DEPTH) - {1'b0, front_r});

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL_CNT)
    else $error("occupancy exceeds depth");

  a_span_matches: assert property (@(posedge clk) disable iff (!rst_n)
    (is_full ? (span == '0) : ((AW+1)'(cnt_r) == span)))
    else $error("index distance disagrees with occupancy");

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held without an output entry");

  a_pop_front_count: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_word.kind == cdq_pkg::KIND_POP_FRONT && !is_empty)
      |=> (cnt_r == $past(cnt_r) - CW'(1)))
    else $error("pop front did not lower occupancy");

  a_full_push_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_word.kind == cdq_pkg::KIND_PUSH_BACK && is_full)
      |=> (cnt_r == $past(cnt_r) && back_r == $past(back_r)))
    else $error("refused push changed the queue");

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for circular_double_ended_queue_core
// A short table of directed operations covers the empty and reset cases, the
// extreme words and every operation. A long random run then fills the queue
// to capacity, drains it from both ends and mixes all operations. Each result
// word is compared field by field with the table or with a behavioral deque
// in the bench; the run steps through sender-gap and receiver-stall phases.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned DEPTH      = 1024;
  localparam int unsigned N_DIRECTED = 21;
  localparam int unsigned N_RANDOM   = 1980;
  localparam longint      LIMIT_NS   = 10_000_000;

  localparam logic [cdq_pkg::WORD_W-1:0] ONES  = {cdq_pkg::WORD_W{1'b1}};
  localparam logic [cdq_pkg::WORD_W-1:0] ALT_A = 64'hAAAA_AAAA_AAAA_AAAA;
  localparam logic [cdq_pkg::WORD_W-1:0] ALT_5 = 64'h5555_5555_5555_5555;

  typedef enum {FILL_UP, DRAIN_DOWN, MIXED} stim_mode_t;

  typedef struct {
    cdq_pkg::kind_t             kind;
    logic [cdq_pkg::WORD_W-1:0] value;
    bit                         typed;
    cdq_pkg::out_word_t         want;
  } dir_row_t;

  logic               clk;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  cdq_pkg::in_word_t  in_word   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  cdq_pkg::out_word_t out_word;

  int send_idle_pct  = 0;
  int stall_pct      = 0;
  int mismatch_count = 0;

  cdq_pkg::out_word_t pending_results[$];
  dir_row_t           rows [N_DIRECTED];

  logic [cdq_pkg::WORD_W-1:0] dq_mem [DEPTH];
  int unsigned                dq_head  = 0;
  int unsigned                dq_tail  = 0;
  int unsigned                dq_count = 0;

  circular_double_ended_queue_core #(
    .DEPTH(DEPTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(LIMIT_NS);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic cdq_pkg::out_word_t deque_step(cdq_pkg::in_word_t w);
    cdq_pkg::out_word_t r;
    r = '0;
    r.status = cdq_pkg::STATUS_OK;
    case (w.kind)
      cdq_pkg::KIND_PUSH_BACK: begin
        if (dq_count >= DEPTH) begin
          r.status = cdq_pkg::STATUS_PUSH_FULL;
        end else begin
          dq_mem[dq_tail] = w.value;
          dq_tail = (dq_tail + 1) % DEPTH;
          dq_count++;
        end
      end
      cdq_pkg::KIND_POP_FRONT: begin
        if (dq_count == 0) begin
          r.status = cdq_pkg::STATUS_POP_EMPTY;
        end else begin
          r.popped_value = dq_mem[dq_head];
          dq_head = (dq_head + 1) % DEPTH;
          dq_count--;
        end
      end
      cdq_pkg::KIND_POP_BACK: begin
        if (dq_count == 0) begin
          r.status = cdq_pkg::STATUS_POP_EMPTY;
        end else begin
          dq_tail = (dq_tail + DEPTH - 1) % DEPTH;
          r.popped_value = dq_mem[dq_tail];
          dq_count--;
        end
      end
      cdq_pkg::KIND_CLEAR: begin
        dq_head = 0;
        dq_tail = 0;
        dq_count = 0;
      end
    endcase
    r.count    = cdq_pkg::COUNT_W'(dq_count);
    r.is_empty = (dq_count == 0);
    r.is_full  = (dq_count == DEPTH);
    if (dq_count != 0) begin
      r.front_value = dq_mem[dq_head];
      r.back_value  = dq_mem[(dq_tail + DEPTH - 1) % DEPTH];
    end
    return r;
  endfunction

  function automatic cdq_pkg::out_word_t mk_res(logic [cdq_pkg::WORD_W-1:0] popped,
                                                cdq_pkg::status_t st,
                                                int unsigned cnt, logic empty, logic full,
                                                logic [cdq_pkg::WORD_W-1:0] front,
                                                logic [cdq_pkg::WORD_W-1:0] back);
    cdq_pkg::out_word_t r;
    r.popped_value = popped;
    r.status       = st;
    r.count        = cdq_pkg::COUNT_W'(cnt);
    r.is_empty     = empty;
    r.is_full      = full;
    r.front_value  = front;
    r.back_value   = back;
    return r;
  endfunction

  function automatic cdq_pkg::in_word_t rand_word(stim_mode_t mode);
    cdq_pkg::in_word_t w;
    int unsigned       r;
    r = $urandom_range(99);
    case (mode)
      FILL_UP: begin
        w.kind = (r < 95) ? cdq_pkg::KIND_PUSH_BACK :
                 (r < 98) ? cdq_pkg::KIND_POP_FRONT : cdq_pkg::KIND_POP_BACK;
      end
      DRAIN_DOWN: begin
        w.kind = (r < 4)  ? cdq_pkg::KIND_PUSH_BACK :
                 (r < 52) ? cdq_pkg::KIND_POP_FRONT : cdq_pkg::KIND_POP_BACK;
      end
      default: begin
        w.kind = (r < 48) ? cdq_pkg::KIND_PUSH_BACK :
                 (r < 72) ? cdq_pkg::KIND_POP_FRONT :
                 (r < 96) ? cdq_pkg::KIND_POP_BACK : cdq_pkg::KIND_CLEAR;
      end
    endcase
    case ($urandom_range(9))
      0:       w.value = '0;
      1:       w.value = ONES;
      default: w.value = {$urandom, $urandom};
    endcase
    return w;
  endfunction

  task automatic send_word(input cdq_pkg::in_word_t w, input bit typed,
                           input cdq_pkg::out_word_t want);
    cdq_pkg::out_word_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    pred = deque_step(w);
    pending_results.push_back(typed ? want : pred);
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    cdq_pkg::out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result word with no expectation waiting");
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_word.popped_value !== want.popped_value) begin
          $error("popped_value: expected %h, actual %h", want.popped_value,
                 out_word.popped_value);
          mismatch_count++;
        end
        if (out_word.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_word.status);
          mismatch_count++;
        end
        if (out_word.count !== want.count) begin
          $error("count: expected %0d, actual %0d", want.count, out_word.count);
          mismatch_count++;
        end
        if (out_word.is_empty !== want.is_empty) begin
          $error("is_empty: expected %b, actual %b", want.is_empty, out_word.is_empty);
          mismatch_count++;
        end
        if (out_word.is_full !== want.is_full) begin
          $error("is_full: expected %b, actual %b", want.is_full, out_word.is_full);
          mismatch_count++;
        end
        if (out_word.front_value !== want.front_value) begin
          $error("front_value: expected %h, actual %h", want.front_value,
                 out_word.front_value);
          mismatch_count++;
        end
        if (out_word.back_value !== want.back_value) begin
          $error("back_value: expected %h, actual %h", want.back_value,
                 out_word.back_value);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    cdq_pkg::in_word_t w;
    stim_mode_t        mode;
    int                mix_left;
    int                phase;

    rows = '{
      '{cdq_pkg::KIND_POP_FRONT, '0, 1'b1,
        mk_res('0, cdq_pkg::STATUS_POP_EMPTY, 0, 1'b1, 1'b0, '0, '0)},
      '{cdq_pkg::KIND_POP_BACK, ONES, 1'b1,
        mk_res('0, cdq_pkg::STATUS_POP_EMPTY, 0, 1'b1, 1'b0, '0, '0)},
      '{cdq_pkg::KIND_CLEAR, ONES, 1'b1,
        mk_res('0, cdq_pkg::STATUS_OK, 0, 1'b1, 1'b0, '0, '0)},
      '{cdq_pkg::KIND_PUSH_BACK, '0, 1'b1,
        mk_res('0, cdq_pkg::STATUS_OK, 1, 1'b0, 1'b0, '0, '0)},
      '{cdq_pkg::KIND_PUSH_BACK, ONES, 1'b1,
        mk_res('0, cdq_pkg::STATUS_OK, 2, 1'b0, 1'b0, '0, ONES)},
      '{cdq_pkg::KIND_PUSH_BACK, ALT_A, 1'b0, '0},
      '{cdq_pkg::KIND_PUSH_BACK, ALT_5, 1'b0, '0},
      '{cdq_pkg::KIND_POP_FRONT, ALT_A, 1'b1,
        mk_res('0, cdq_pkg::STATUS_OK, 3, 1'b0, 1'b0, ONES, ALT_5)},
      '{cdq_pkg::KIND_POP_BACK, '0, 1'b1,
        mk_res(ALT_5, cdq_pkg::STATUS_OK, 2, 1'b0, 1'b0, ONES, ALT_A)},
      '{cdq_pkg::KIND_POP_FRONT, '0, 1'b1,
        mk_res(ONES, cdq_pkg::STATUS_OK, 1, 1'b0, 1'b0, ALT_A, ALT_A)},
      '{cdq_pkg::KIND_CLEAR, '0, 1'b1,
        mk_res('0, cdq_pkg::STATUS_OK, 0, 1'b1, 1'b0, '0, '0)},
      '{cdq_pkg::KIND_POP_BACK, '0, 1'b1,
        mk_res('0, cdq_pkg::STATUS_POP_EMPTY, 0, 1'b1, 1'b0, '0, '0)},
      '{cdq_pkg::KIND_PUSH_BACK, 64'h8000_0000_0000_0001, 1'b0, '0},
      '{cdq_pkg::KIND_PUSH_BACK, 64'h0123_4567_89AB_CDEF, 1'b0, '0},
      '{cdq_pkg::KIND_POP_BACK,  ALT_5, 1'b0, '0},
      '{cdq_pkg::KIND_POP_BACK,  '0,    1'b0, '0},
      '{cdq_pkg::KIND_POP_FRONT, '0,    1'b0, '0},
      '{cdq_pkg::KIND_PUSH_BACK, 64'hFEDC_BA98_7654_3210, 1'b0, '0},
      '{cdq_pkg::KIND_POP_FRONT, ONES,  1'b0, '0},
      '{cdq_pkg::KIND_PUSH_BACK, ALT_5, 1'b0, '0},
      '{cdq_pkg::KIND_CLEAR,     ALT_A, 1'b0, '0}
    };

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) begin
      w.kind  = rows[i].kind;
      w.value = rows[i].value;
      send_word(w, rows[i].typed, rows[i].want);
    end

    // The random run starts mixed, then fills to capacity, pushes against a
    // full queue for a while and drains it again from both ends.
    mode     = MIXED;
    mix_left = 100;
    phase    = -1;
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i / (N_RANDOM / 4) != phase) begin
        phase = i / (N_RANDOM / 4);
        hold_until_drained();
        case (phase)
          0: begin
            send_idle_pct = 0;
            stall_pct     = 0;
          end
          1: begin
            send_idle_pct = 78;
            stall_pct     = 0;
          end
          2: begin
            send_idle_pct = 0;
            stall_pct     = 78;
          end
          default: begin
            send_idle_pct = 25;
            stall_pct     = 25;
          end
        endcase
      end
      send_word(rand_word(mode), 1'b0, '0);
      case (mode)
        FILL_UP: begin
          if (dq_count == DEPTH && $urandom_range(3) == 0) mode = DRAIN_DOWN;
        end
        DRAIN_DOWN: begin
          if (dq_count == 0 && $urandom_range(3) == 0) begin
            mode     = MIXED;
            mix_left = 100;
          end
        end
        default: begin
          mix_left--;
          if (mix_left <= 0) mode = FILL_UP;
        end
      endcase
    end

    hold_until_drained();
    stall_pct = 0;
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
